### rtl/core/gshp_pkg.sv
// Shared types, codes and constants of the gain-scheduled heading PID core.
// No dependencies; every other file of the core imports this package.
package gshp_pkg;

   typedef enum logic {
      REQ_TICK  = 1'b0,
      REQ_START = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_RUN     = 2'd0,
      ST_REACHED = 2'd1,
      ST_STOP    = 2'd2,
      ST_IDLE    = 2'd3
   } loop_status_type;

   typedef enum logic {
      CSR_TARGET = 1'b0,
      CSR_LIMIT  = 1'b1
   } csr_index_type;

   localparam int ANGLE_W  = 16;
   localparam int MV_W     = 14;
   localparam int DRIVE_W  = 16;
   localparam int ERR_W    = 17;
   localparam int INTEG_W  = 22;
   localparam int TICK_W   = 16;
   localparam int CSR_W    = 16;

   // tick_limit / 100 by reciprocal: (x * 83887) >> 23 is exact for 16-bit x
   localparam int LIMIT_RECIP_W = 17;
   localparam logic [LIMIT_RECIP_W-1:0] LIMIT_RECIP = 17'd83887;
   localparam int LIMIT_SHIFT = 23;
   localparam int LIMIT_Q_W   = 10;

   localparam int INT_WINDOW = 500;
   localparam int DRIVE_MAX  = 32767;
   localparam int INTEG_MAX  = 2097151;
   localparam int INTEG_MIN  = -2097152;

   localparam logic [MV_W-1:0] BAND_HI_MV  = 14'd8200;
   localparam logic [MV_W-1:0] BAND_MID_MV = 14'd7900;
   localparam logic [MV_W-1:0] BAND_LO_MV  = 14'd7700;

   localparam int KP_MILLI [4] = '{1000, 1200, 1400, 1500};
   localparam int KI_MILLI [4] = '{450, 650, 770, 800};
   localparam int KD_MILLI [4] = '{3500, 3600, 3500, 3500};

   typedef struct packed {
      req_kind_type            kind;
      logic signed [ANGLE_W-1:0] angle;
      logic [MV_W-1:0]         mv;
   } req_item_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      loop_status_type           status;
      logic signed [ERR_W-1:0]   error;
   } rsp_item_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] target;
      logic [LIMIT_Q_W-1:0]      limit_ticks;
   } cfg_type;

   // gain in Q.frac, rounded to nearest; elaboration use only
   function automatic int gain_q(input int milli, input int frac);
      return ((milli << frac) + 500) / 1000;
   endfunction

endpackage

### rtl/core/gshp_cfg.sv
// Configuration registers: heading target and tick limit in whole ticks.
// Depends on gshp_pkg.
module gshp_cfg
   import gshp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [CSR_W-1:0] csr_wdata,
   output cfg_type          cfg
);

   logic signed [ANGLE_W-1:0]           target_ff;
   logic [LIMIT_Q_W-1:0]                limit_q_ff;
   logic [CSR_W+LIMIT_RECIP_W-1:0]      limit_prod;

   assign limit_prod = (CSR_W+LIMIT_RECIP_W)'(csr_wdata) *
                       (CSR_W+LIMIT_RECIP_W)'(LIMIT_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= '0;
         limit_q_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_TARGET: target_ff  <= signed'(csr_wdata);
            CSR_LIMIT:  limit_q_ff <= limit_prod[LIMIT_SHIFT +: LIMIT_Q_W];
            default:    target_ff  <= target_ff;
         endcase
      end
   end

   assign cfg.target      = target_ff;
   assign cfg.limit_ticks = limit_q_ff;

endmodule

### rtl/core/gshp_step.sv
// Loop state and one PID step: band select, P/I/D terms, truncation, saturation.
// Depends on gshp_pkg; state advances on each item handed on by the top level.
module gshp_step
   import gshp_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 8
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type rsp
);

   localparam int F  = GAIN_FRAC_BITS;
   localparam int GW = F + 3;
   localparam int BW = ((ERR_W + F > INTEG_W) ? ERR_W + F : INTEG_W) + 1;
   localparam int IW = BW + GW;
   localparam int PW = ERR_W + GW;
   localparam int DW = ERR_W + 1 + GW;
   localparam int SW = ((DW > INTEG_W) ? DW : INTEG_W) + 2;

   localparam logic signed [GW-1:0] KP_TAB [4] = '{
      GW'(gain_q(KP_MILLI[0], F)), GW'(gain_q(KP_MILLI[1], F)),
      GW'(gain_q(KP_MILLI[2], F)), GW'(gain_q(KP_MILLI[3], F))};
   localparam logic signed [GW-1:0] KI_TAB [4] = '{
      GW'(gain_q(KI_MILLI[0], F)), GW'(gain_q(KI_MILLI[1], F)),
      GW'(gain_q(KI_MILLI[2], F)), GW'(gain_q(KI_MILLI[3], F))};
   localparam logic signed [GW-1:0] KD_TAB [4] = '{
      GW'(gain_q(KD_MILLI[0], F)), GW'(gain_q(KD_MILLI[1], F)),
      GW'(gain_q(KD_MILLI[2], F)), GW'(gain_q(KD_MILLI[3], F))};

   logic [TICK_W-1:0]          tick_ff, tick_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [ERR_W-1:0]    prev_ff, prev_in;
   logic signed [ERR_W-1:0]    cur_ff, cur_in;
   logic signed [DRIVE_W-1:0]  held_ff, held_in;
   logic                       active_ff, active_in;

   logic signed [ERR_W-1:0]    err;
   logic signed [ERR_W:0]      derr;
   logic [1:0]                 band;
   logic                       in_window;
   logic signed [BW-1:0]       base;
   logic signed [IW-1:0]       iprod, iprod_adj, itrunc;
   logic signed [INTEG_W-1:0]  integ_step;
   logic signed [PW-1:0]       pterm;
   logic signed [DW-1:0]       dterm;
   logic signed [SW-1:0]       sum, sum_adj, strunc;
   logic signed [DRIVE_W-1:0]  drive_step;

   assign err  = {cfg.target[ANGLE_W-1], cfg.target} - {item.angle[ANGLE_W-1], item.angle};
   assign derr = {err[ERR_W-1], err} - {prev_ff[ERR_W-1], prev_ff};

   always_comb begin
      priority if (item.mv > BAND_HI_MV)
         band = 2'd0;
      else if (item.mv > BAND_MID_MV && item.mv < BAND_HI_MV)
         band = 2'd1;
      else if (item.mv > BAND_LO_MV && item.mv < BAND_MID_MV)
         band = 2'd2;
      else
         band = 2'd3;
   end

   assign in_window = (err > ERR_W'(-INT_WINDOW)) && (err < ERR_W'(INT_WINDOW));

   // integral: (acc + e) * kI, truncated toward zero, saturated to 22 bits, zero outside the window
   assign base      = BW'(integ_ff) + (BW'(err) <<< F);
   assign iprod     = IW'(base) * IW'(KI_TAB[band]);
   assign iprod_adj = iprod + (iprod[IW-1] ? IW'(2**F - 1) : IW'(0));
   assign itrunc    = iprod_adj >>> F;

   always_comb begin
      priority if (!in_window)
         integ_step = '0;
      else if (itrunc > IW'(INTEG_MAX))
         integ_step = INTEG_W'(INTEG_MAX);
      else if (itrunc < IW'(INTEG_MIN))
         integ_step = INTEG_W'(INTEG_MIN);
      else
         integ_step = itrunc[INTEG_W-1:0];
   end

   assign pterm   = PW'(err) * PW'(KP_TAB[band]);
   assign dterm   = DW'(derr) * DW'(KD_TAB[band]);
   assign sum     = SW'(pterm) + SW'(integ_step) + SW'(dterm);
   assign sum_adj = sum + (sum[SW-1] ? SW'(2**F - 1) : SW'(0));
   assign strunc  = sum_adj >>> F;

   always_comb begin
      priority if (strunc > SW'(DRIVE_MAX))
         drive_step = DRIVE_W'(DRIVE_MAX);
      else if (strunc < SW'(-DRIVE_MAX))
         drive_step = DRIVE_W'(-DRIVE_MAX);
      else
         drive_step = strunc[DRIVE_W-1:0];
   end

   always_comb begin
      tick_in    = tick_ff;
      integ_in   = integ_ff;
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      held_in    = held_ff;
      active_in  = active_ff;
      rsp.drive  = held_ff;
      rsp.status = ST_RUN;
      priority if (item.kind == REQ_START) begin
         tick_in   = '0;
         integ_in  = '0;
         prev_in   = '0;
         cur_in    = err;
         active_in = 1'b1;
      end else if (!active_ff) begin
         rsp.status = ST_IDLE;
      end else if (item.angle == cfg.target) begin
         active_in  = 1'b0;
         rsp.status = ST_REACHED;
      end else if (tick_ff == TICK_W'(cfg.limit_ticks) ||
                   (cur_ff == '0 && prev_ff == '0)) begin
         active_in  = 1'b0;
         held_in    = '0;
         rsp.drive  = '0;
         rsp.status = ST_STOP;
      end else begin
         integ_in  = integ_step;
         prev_in   = err;
         cur_in    = err;
         held_in   = drive_step;
         rsp.drive = drive_step;
         tick_in   = tick_ff + 1'b1;
      end
      rsp.error = cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         integ_ff  <= '0;
         prev_ff   <= '0;
         cur_ff    <= '0;
         held_ff   <= '0;
         active_ff <= 1'b0;
      end else if (fire) begin
         tick_ff   <= tick_in;
         integ_ff  <= integ_in;
         prev_ff   <= prev_in;
         cur_ff    <= cur_in;
         held_ff   <= held_in;
         active_ff <= active_in;
      end
   end

endmodule

### rtl/core/gain_scheduled_heading_pid_core.sv
// Top level of the gain-scheduled heading PID core: request register, result register.
// Depends on gshp_pkg, gshp_cfg and gshp_step.
//
//   channel | direction | payload
//   req_    | in        | tuser: req_type; tdata: angle_sample, battery_mv
//   rsp_    | out       | tuser: loop_status; tdata: drive_out, error_out
//   csr_    | in        | csr_addr 0 target_angle, 1 tick_limit; write only
//
// One request per cycle unless a stalled result holds the request register.
// The PID step sits between the request register and the result register.
// Reset clears loop state, configuration registers and valid flags; the loop comes up idle.
// A stalled result holds; the request register keeps taking a new request
// whenever the step can hand its result on in the same cycle.
module gain_scheduled_heading_pid_core
   import gshp_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 8
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // [15:0] angle_sample, [29:16] battery_mv, rest 0
   input  logic             req_tuser,   // [0] req_type
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,   // [15:0] drive_out, [32:16] error_out, rest 0
   output logic [1:0]       rsp_tuser,   // [1:0] loop_status
   input  logic             csr_we,
   input  logic             csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   req_item_type item_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type rsp_ff, rsp_step;
   logic         rsp_valid_ff, rsp_valid_in;
   cfg_type      cfg;
   logic         advance, accept;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind  <= req_kind_type'(req_tuser);
         item_ff.angle <= signed'(req_tdata[ANGLE_W-1:0]);
         item_ff.mv    <= req_tdata[ANGLE_W +: MV_W];
      end
      if (advance) begin
         rsp_ff <= rsp_step;
      end
   end

   gshp_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gshp_step #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_step (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (item_ff),
      .cfg   (cfg),
      .rsp   (rsp_step)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.error, rsp_ff.drive};
   assign rsp_tuser  = rsp_ff.status;

   a_stop_zero_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_STOP |-> rsp_ff.drive == '0)
      else $error("stop result with nonzero drive");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.drive != {1'b1, {(DRIVE_W-1){1'b0}}})
      else $error("drive outside saturation range");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.kind == REQ_START |=> rsp_ff.status == ST_RUN)
      else $error("start request did not report running");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_tready)
      else $error("request register overwritten before hand-on");

endmodule

### bench/tb_gain_scheduled_heading_pid_core.sv
// Self-checking bench for gain_scheduled_heading_pid_core: directed turns, then random turns
// under request gaps and result stalls, each result checked against an in-bench PID predictor.
// Depends on gshp_pkg and the core RTL.
module tb_gain_scheduled_heading_pid_core;
   import gshp_pkg::*;

   localparam int FRAC            = 8;
   localparam int RANDOM_REQUESTS = 760;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 4;
   localparam int MV_EDGES [10]   = '{0, 7699, 7700, 7701, 7899, 7900, 7901, 8199, 8200, 8201};

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_type;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata  = '0;
   logic             req_tuser  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [39:0]      rsp_tdata;
   logic [1:0]       rsp_tuser;
   logic             csr_we     = 1'b0;
   logic             csr_addr   = 1'b0;
   logic [CSR_W-1:0] csr_wdata  = '0;

   gain_scheduled_heading_pid_core #(.GAIN_FRAC_BITS(FRAC)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // predicted regulator state
   rsp_item_type              pending_results[$];
   logic signed [ANGLE_W-1:0] heading_target = '0;
   logic [CSR_W-1:0]          tick_budget    = '0;
   logic [TICK_W-1:0]         turn_ticks     = '0;
   longint                    integ_q        = 0;
   int                        last_error     = 0;
   int                        live_error     = 0;
   int                        held_drive     = 0;
   bit                        turn_active    = 1'b0;

   int          burst_left      = 0;
   int          requests_sent   = 0;
   int          settings_used   = 0;
   int          results_checked = 0;
   int          mismatches      = 0;
   int          status_seen [4] = '{0, 0, 0, 0};
   int          quiet_cycles    = 0;
   int          hold_off_left   = 0;
   bit          hold_off_request = 1'b0;
   int          pattern_left    = 0;
   rx_mode_type rx_mode         = RX_OPEN;

   function automatic int spread(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int clamp_angle(input int a);
      if (a > 32767) return 32767;
      if (a < -32768) return -32768;
      return a;
   endfunction

   function automatic longint saturate(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint q_gain(input int milli);
      return ((longint'(milli) << FRAC) + 500) / 1000;
   endfunction

   function automatic int gain_band(input logic [MV_W-1:0] mv);
      if (mv > BAND_HI_MV) return 0;
      if (mv > BAND_MID_MV && mv < BAND_HI_MV) return 1;
      if (mv > BAND_LO_MV && mv < BAND_MID_MV) return 2;
      return 3;
   endfunction

   function automatic int random_mv();
      case ($urandom_range(0, 3))
         0: return MV_EDGES[$urandom_range(0, 9)];
         1: return spread(0, 16383);
         default: return spread(7500, 8400);
      endcase
   endfunction

   task automatic predict_heading_step(input req_kind_type kind,
                                       input logic signed [ANGLE_W-1:0] angle,
                                       input logic [MV_W-1:0] mv);
      rsp_item_type res;
      int           e;
      int           band;
      longint       sum;
      res.drive = held_drive[DRIVE_W-1:0];
      if (kind == REQ_START) begin
         turn_ticks = '0;
         integ_q = 0;
         last_error = 0;
         live_error = int'(heading_target) - int'(angle);
         turn_active = 1'b1;
         res.status = ST_RUN;
      end else if (!turn_active) begin
         res.status = ST_IDLE;
      end else if (angle == heading_target) begin
         turn_active = 1'b0;
         res.status = ST_REACHED;
      end else if (turn_ticks == tick_budget / 100 || (live_error == 0 && last_error == 0)) begin
         turn_active = 1'b0;
         held_drive = 0;
         res.drive = '0;
         res.status = ST_STOP;
      end else begin
         e = int'(heading_target) - int'(angle);
         band = gain_band(mv);
         if (e > -INT_WINDOW && e < INT_WINDOW)
            integ_q = saturate(((integ_q + (longint'(e) << FRAC)) * q_gain(KI_MILLI[band]))
                               / (longint'(1) << FRAC), INTEG_MIN, INTEG_MAX);
         else
            integ_q = 0;
         sum = (longint'(e) * q_gain(KP_MILLI[band]) + integ_q
                + longint'(e - last_error) * q_gain(KD_MILLI[band])) / (longint'(1) << FRAC);
         held_drive = int'(saturate(sum, -DRIVE_MAX, DRIVE_MAX));
         res.drive = held_drive[DRIVE_W-1:0];
         last_error = e;
         live_error = e;
         turn_ticks = turn_ticks + 1'b1;
         res.status = ST_RUN;
      end
      res.error = live_error[ERR_W-1:0];
      pending_results.push_back(res);
   endtask

   // offer one request, with bursts and gaps, and predict it once taken
   task automatic send_request(input req_kind_type kind, input int angle, input int mv);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, mv[MV_W-1:0], angle[ANGLE_W-1:0]};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      predict_heading_step(kind, angle[ANGLE_W-1:0], mv[MV_W-1:0]);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input int target, input int limit);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_TARGET;
      csr_wdata <= target[CSR_W-1:0];
      @(posedge clock);
      heading_target = target[ANGLE_W-1:0];
      csr_addr  <= CSR_LIMIT;
      csr_wdata <= limit[CSR_W-1:0];
      @(posedge clock);
      tick_budget = limit[CSR_W-1:0];
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic test_idle_ticks();
      send_request(REQ_TICK, 0, 0);
      send_request(REQ_TICK, -32768, 16383);
      drain_results();
   endtask

   task automatic test_extremes();
      write_registers(32767, 65535);
      send_request(REQ_START, -32768, 0);
      send_request(REQ_TICK, -32768, 16383);
      send_request(REQ_TICK, -32768, 0);
      send_request(REQ_TICK, 32767, 8201);
      send_request(REQ_TICK, 0, 8000);
      drain_results();
      write_registers(-32768, 200);
      send_request(REQ_START, 32767, 7800);
      send_request(REQ_TICK, 32767, 7800);
      send_request(REQ_TICK, 30000, 16383);
      send_request(REQ_TICK, 0, 9000);
      drain_results();
      write_registers(-32768, 0);
      send_request(REQ_START, 32767, 7800);
      send_request(REQ_TICK, 32767, 7800);
      drain_results();
   endtask

   task automatic test_settle();
      write_registers(100, 65535);
      send_request(REQ_START, 100, 8100);
      send_request(REQ_TICK, 40, 8100);
      drain_results();
   endtask

   task automatic test_gain_bands();
      int a;
      write_registers(0, 1000);
      send_request(REQ_START, 10, 8000);
      a = 12;
      for (int i = 1; i < 10; i++) begin
         send_request(REQ_TICK, a, MV_EDGES[i]);
         a = -a + 3;
      end
      send_request(REQ_TICK, 0, 8000);
      drain_results();
   endtask

   // stall results for a long stretch while requests keep coming
   task automatic test_backpressure();
      write_registers(0, 65535);
      hold_off_request = 1'b1;
      send_request(REQ_START, 300, random_mv());
      for (int i = 0; i < 40; i++)
         send_request(REQ_TICK, spread(-400, 400), random_mv());
      drain_results();
   endtask

   task automatic run_turn();
      int offset;
      if ($urandom_range(0, 9) != 0) begin
         case ($urandom_range(0, 7))
            0: offset = 0;
            1: offset = spread(-40000, 40000);
            default: offset = spread(-800, 800);
         endcase
         send_request(REQ_START, clamp_angle(heading_target - offset), random_mv());
      end else begin
         offset = spread(-100, 100);
      end
      repeat ($urandom_range(1, 30)) begin
         case ($urandom_range(0, 31))
            0: send_request(REQ_TICK, heading_target, random_mv());
            1: send_request(REQ_TICK, spread(-32768, 32767), random_mv());
            2: send_request(REQ_START, clamp_angle(heading_target - offset), random_mv());
            default: begin
               offset = offset * 3 / 4 + (($urandom_range(0, 3) == 0) ? spread(-20, 20) : 0);
               send_request(REQ_TICK, clamp_angle(heading_target - offset), random_mv());
            end
         endcase
      end
   endtask

   task automatic test_random_turns();
      int goal;
      int target;
      int limit;
      goal = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < goal) begin
         case ($urandom_range(0, 4))
            0: target = -32768;
            1: target = 32767;
            2: target = 0;
            3: target = spread(-2000, 2000);
            default: target = spread(-32768, 32767);
         endcase
         case ($urandom_range(0, 4))
            0: limit = 0;
            1: limit = 65535;
            2: limit = spread(100, 3000);
            3: limit = spread(0, 199);
            default: limit = spread(0, 65535);
         endcase
         write_registers(target, limit);
         repeat ($urandom_range(2, 6)) run_turn();
         drain_results();
      end
   endtask

   always @(posedge clock) begin : result_ready_pattern
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_off_left = HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 96);
         end
         pattern_left--;
         case (rx_mode)
            RX_OPEN: rsp_tready <= 1'b1;
            RX_COIN: rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= (pattern_left % 4 != 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      rsp_item_type              want;
      logic signed [DRIVE_W-1:0] got_drive;
      logic signed [ERR_W-1:0]   got_error;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got_drive = rsp_tdata[15:0];
         got_error = rsp_tdata[32:16];
         if (pending_results.size() == 0) begin
            $error("unexpected result: drive_out %0d loop_status %0d error_out %0d",
                   got_drive, rsp_tuser, got_error);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            status_seen[rsp_tuser]++;
            if (got_drive !== want.drive) begin
               $error("drive_out expected %0d actual %0d", want.drive, got_drive);
               mismatches++;
            end
            if (rsp_tuser !== want.status) begin
               $error("loop_status expected %0d actual %0d", want.status, rsp_tuser);
               mismatches++;
            end
            if (got_error !== want.error) begin
               $error("error_out expected %0d actual %0d", want.error, got_error);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin : count_quiet_cycles
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_idle_ticks();
      test_extremes();
      test_settle();
      test_gain_bands();
      test_backpressure();
      test_random_turns();
      drain_results();
      $display("Sent %0d requests over %0d register settings; checked %0d results.",
               requests_sent, settings_used, results_checked);
      $display("Results by status: running %0d, reached %0d, stopped %0d, idle %0d.",
               status_seen[ST_RUN], status_seen[ST_REACHED], status_seen[ST_STOP],
               status_seen[ST_IDLE]);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
